/* rtl/crq_pkg.sv */
// package for the coalescing report queue
// constants, status codes, register indexes; no dependencies
package crq_pkg;
    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int TRACKER_COUNT_DEF = 8;
    localparam int DATA_SLOTS_DEF = 3;
    localparam logic [7:0] TYPE_MAX_VALID = 8'd223;
    localparam logic [7:0] TYPE_REG = 8'd255;
    localparam logic [7:0] TYPE_KEEP_A = 8'd1;
    localparam logic [7:0] TYPE_KEEP_B = 8'd4;
    localparam logic [15:0] PERIOD_RESET = 16'd100;

    typedef enum logic [1:0] {
        KIND_ENQ = 2'd0, KIND_TRK = 2'd1, KIND_CLR = 2'd2, KIND_REP = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_QUEUED = 3'd0, ST_REPLACED = 3'd1, ST_DROPPED = 3'd2,
        ST_TRK_DONE = 3'd3, ST_REPORT = 3'd4, ST_NO_REPORT = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_PERIOD = 3'd0, REG_TYPE = 3'd1, REG_MARKER = 3'd2,
        REG_MAGIC = 3'd3, REG_VERSION = 3'd4, REG_END = 3'd5
    } t_reg;
endpackage

/* rtl/crq_ram.sv */
// generic single-port-write, single-read ram with registered read
// no dependencies
module crq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/coalescing_report_queue.sv */
// coalescing report queue top level
// uses crq_pkg and crq_ram
//
// one input channel (valid/ready), one result channel (valid/ready), apb config port.
// kind 0 queues a 16-byte record, optionally overwriting the oldest record of the
// same sensor; kind 1 sets a tracker; kind 2 clears trackers and queue; kind 3
// builds a report of DATA_SLOTS data slots plus a metadata slot.
// one item at a time: ready is low from acceptance until its last result is loaded
// into the result register. enqueue with replace scans the queue from the read
// pointer, one entry at a time through the single ram read port (read, then compare).
// other enqueues and tracker/clear items write, make a tracker pass and respond; a
// report drains records (read, wait, take), makes a tracker pass, fills free slots
// from the tracker table, then emits one result per slot.
// the registration check walks the tracker table one entry a cycle.
// reset empties queue pointers and tracker table, sets registers to defaults;
// queue ram contents are not cleared. a stalled receiver holds the result
// register and the sequencer waits.
module coalescing_report_queue
    import crq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TRACKER_COUNT = TRACKER_COUNT_DEF,
    parameter int DATA_SLOTS = DATA_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_data_low,
    input  logic [63:0] i_data_high,
    input  logic [7:0]  i_rssi,
    input  logic [7:0]  i_sequence_req,
    input  logic [7:0]  i_flags,
    input  logic        i_replace_same_sensor,
    input  logic [7:0]  i_tracker_id,
    input  logic [47:0] i_tracker_address,
    input  logic [47:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_word_low,
    output logic [63:0] o_word_high,
    output logic [1:0]  o_slot,
    output logic        o_last,
    output logic        o_pending,
    output logic [31:0] o_drop_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int TW = (TRACKER_COUNT > 1) ? $clog2(TRACKER_COUNT) : 1;
    localparam int SW = 2;
    localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [TW-1:0] TLAST = TW'(TRACKER_COUNT - 1);
    localparam logic [SW-1:0] SLAST = SW'(DATA_SLOTS);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SREAD  = 12'b000000000010,
        S_SCMP   = 12'b000000000100,
        S_WRITE  = 12'b000000001000,
        S_DUE    = 12'b000000010000,
        S_RESP   = 12'b000000100000,
        S_DREAD  = 12'b000001000000,
        S_DWAIT  = 12'b000010000000,
        S_DTAKE  = 12'b000100000000,
        S_REG    = 12'b001000000000,
        S_EMIT   = 12'b010000000000,
        S_FINISH = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic [15:0] r_period;
    logic [7:0]  r_mtype, r_mmarker, r_mmagic, r_mversion, r_mend;
    logic [2:0]  w_rix;
    assign w_rix = paddr[4:2];
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_mtype <= '0; r_mmarker <= '0; r_mmagic <= '0;
            r_mversion <= '0; r_mend <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_rix)
                REG_PERIOD:  r_period <= pwdata[15:0];
                REG_TYPE:    r_mtype <= pwdata[7:0];
                REG_MARKER:  r_mmarker <= pwdata[7:0];
                REG_MAGIC:   r_mmagic <= pwdata[7:0];
                REG_VERSION: r_mversion <= pwdata[7:0];
                REG_END:     r_mend <= pwdata[7:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (w_rix)
            REG_PERIOD:  prdata = {16'd0, r_period};
            REG_TYPE:    prdata = {24'd0, r_mtype};
            REG_MARKER:  prdata = {24'd0, r_mmarker};
            REG_MAGIC:   prdata = {24'd0, r_mmagic};
            REG_VERSION: prdata = {24'd0, r_mversion};
            REG_END:     prdata = {24'd0, r_mend};
            default:     prdata = '0;
        endcase
    end

    // captured item
    logic [1:0]  r_kind;
    logic [63:0] r_lo, r_hi;
    logic [23:0] r_meta;
    logic        r_repl;
    logic [7:0]  r_tid;
    logic [47:0] r_taddr, r_now;

    // state
    logic [QW-1:0] r_rp, r_wp, r_cur;
    logic [47:0]   r_trk [TRACKER_COUNT];
    logic [TW-1:0] r_rr;
    logic [47:0]   r_last_ann;
    logic          r_never;
    logic [31:0]   r_drops;

    // work registers
    logic [TW-1:0] r_ti;
    logic [TW:0]   r_tcnt;
    logic          r_any;
    logic          r_due;
    logic          r_fill;
    logic [SW-1:0] r_sl;
    logic [SW-1:0] r_nq;
    logic [3:0]    r_nvalid;
    logic [63:0]   r_wl [DATA_SLOTS];
    logic [63:0]   r_wh [DATA_SLOTS];
    logic [23:0]   r_wm [DATA_SLOTS];
    logic [2:0]    r_status;

    // memories
    logic          w_we;
    logic [QW-1:0] w_waddr, w_raddr;
    logic [63:0]   w_qlo, w_qhi;
    logic [23:0]   w_qm;

    crq_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_lo (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_lo),
        .i_raddr(w_raddr), .o_rdata(w_qlo));
    crq_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_hi (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_hi),
        .i_raddr(w_raddr), .o_rdata(w_qhi));
    crq_ram #(.WIDTH(24), .DEPTH(QUEUE_DEPTH)) u_meta (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_meta),
        .i_raddr(w_raddr), .o_rdata(w_qm));

    function automatic logic [QW-1:0] bump(input logic [QW-1:0] p);
        return (p == QLAST) ? '0 : p + 1'b1;
    endfunction

    logic w_in_xfer, w_out_xfer;
    assign o_ready = (r_state == S_IDLE);
    assign w_in_xfer = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;

    logic [QW-1:0] w_wnext;
    logic          w_hit, w_scan_end, w_full;
    assign w_wnext = bump(r_wp);
    assign w_full = (w_wnext == r_rp);
    assign w_scan_end = (r_cur == r_wp);
    assign w_hit = (w_qlo[7:0] <= TYPE_MAX_VALID) && (w_qlo[15:8] == r_lo[15:8]);
    assign w_raddr = r_cur;
    assign w_we = (r_state == S_WRITE) && (r_kind == KIND_ENQ)
        && !(r_status == ST_QUEUED && w_full);
    assign w_waddr = (r_status == ST_REPLACED) ? r_cur : r_wp;

    logic [47:0] w_diff;
    logic        w_due_now, w_tnz;
    assign w_diff = r_now - r_last_ann;
    assign w_tnz = (r_trk[r_ti] != '0);
    assign w_due_now = r_any && (r_never || (w_diff >= {32'd0, r_period}));

    // metadata word
    logic [127:0] w_meta;
    always_comb begin
        w_meta = '0;
        w_meta[7:0] = r_mtype;
        w_meta[15:8] = r_mmarker;
        w_meta[23:16] = r_mmagic;
        w_meta[31:24] = r_mversion;
        w_meta[39:32] = {4'd0, r_nvalid};
        for (int s = 0; s < DATA_SLOTS; s++) begin
            if (SW'(s) < r_nq) w_meta[40 + 24*s +: 24] = r_wm[s];
        end
        w_meta[127:120] = r_mend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp <= '0; r_wp <= '0; r_cur <= '0;
            for (int i = 0; i < TRACKER_COUNT; i++) r_trk[i] <= '0;
            r_rr <= '0;
            r_last_ann <= '0;
            r_never <= 1'b1;
            r_drops <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_RESP || r_state == S_EMIT) && (!o_valid || i_ready))
                o_valid <= 1'b1;
            else if (w_out_xfer) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_kind <= i_kind;
                    r_lo <= i_data_low;
                    r_hi <= (i_data_low[7:0] != TYPE_KEEP_A && i_data_low[7:0] != TYPE_KEEP_B)
                        ? {i_rssi, i_data_high[55:0]} : i_data_high;
                    r_meta <= {i_flags, i_rssi, i_sequence_req};
                    r_repl <= i_replace_same_sensor;
                    r_tid <= i_tracker_id;
                    r_taddr <= i_tracker_address;
                    r_now <= i_now_ms;
                    r_cur <= r_rp;
                    r_status <= ST_QUEUED;
                    r_nq <= '0;
                    r_nvalid <= '0;
                    r_sl <= '0;
                    r_fill <= 1'b1;
                    r_due <= 1'b0;
                    for (int s = 0; s < DATA_SLOTS; s++) begin
                        r_wl[s] <= '0; r_wh[s] <= '0;
                    end
                end
                S_SREAD: ;
                S_SCMP: begin
                    if (w_hit) r_status <= ST_REPLACED;
                    else r_cur <= bump(r_cur);
                end
                S_WRITE: begin
                    if (r_kind == KIND_ENQ) begin
                        if (r_status == ST_QUEUED) begin
                            if (w_full) begin
                                r_drops <= r_drops + 32'd1;
                                r_status <= ST_DROPPED;
                            end else r_wp <= w_wnext;
                        end
                    end else if (r_kind == KIND_TRK) begin
                        if ({1'b0, r_tid} < 9'(TRACKER_COUNT)) r_trk[r_tid[TW-1:0]] <= r_taddr;
                        r_status <= ST_TRK_DONE;
                    end else begin
                        for (int i = 0; i < TRACKER_COUNT; i++) r_trk[i] <= '0;
                        r_rp <= '0; r_wp <= '0; r_rr <= '0;
                        r_status <= ST_TRK_DONE;
                    end
                    r_ti <= '0; r_tcnt <= '0; r_any <= 1'b0;
                end
                S_DREAD: begin
                    r_ti <= '0; r_tcnt <= '0; r_any <= 1'b0;
                end
                S_DWAIT: ;
                S_DTAKE: begin
                    r_wl[r_nq] <= w_qlo;
                    r_wh[r_nq] <= w_qhi;
                    r_wm[r_nq] <= w_qm;
                    if (w_qlo[7:0] <= TYPE_MAX_VALID) r_nvalid <= r_nvalid + 4'd1;
                    r_nq <= r_nq + 1'b1;
                    r_rp <= bump(r_rp);
                    r_cur <= bump(r_cur);
                    r_sl <= r_nq + 1'b1;
                end
                S_DUE: begin
                    if (w_tnz) r_any <= 1'b1;
                    if (r_tcnt == (TW+1)'(TRACKER_COUNT)) begin
                        r_due <= w_due_now;
                        r_ti <= r_rr;
                        r_tcnt <= '0;
                        if (r_kind == KIND_REP && r_nq == '0 && !w_due_now)
                            r_status <= ST_NO_REPORT;
                        else if (r_kind == KIND_REP) r_status <= ST_REPORT;
                    end else begin
                        r_ti <= (r_ti == TLAST) ? '0 : r_ti + 1'b1;
                        r_tcnt <= r_tcnt + 1'b1;
                    end
                end
                S_REG: begin
                    if (r_sl == SLAST || !r_fill) ;
                    else if (r_tcnt == (TW+1)'(TRACKER_COUNT)) r_fill <= 1'b0;
                    else if (w_tnz) begin
                        r_wl[r_sl] <= {r_trk[r_ti], {(8-TW){1'b0}}, r_ti, TYPE_REG};
                        r_rr <= (r_ti == TLAST) ? '0 : r_ti + 1'b1;
                        r_ti <= (r_ti == TLAST) ? '0 : r_ti + 1'b1;
                        r_tcnt <= '0;
                        r_sl <= r_sl + 1'b1;
                        r_due <= 1'b1;
                    end else begin
                        r_ti <= (r_ti == TLAST) ? '0 : r_ti + 1'b1;
                        r_tcnt <= r_tcnt + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (r_due) begin
                        r_last_ann <= r_now;
                        r_never <= 1'b0;
                    end
                    r_ti <= '0; r_tcnt <= '0;
                    r_sl <= '0;
                end
                S_RESP: ;
                S_EMIT: if (!o_valid || i_ready) begin
                    o_status <= ST_REPORT;
                    o_slot <= r_sl;
                    o_last <= (r_sl == SLAST);
                    o_pending <= (r_rp != r_wp) || w_due_now;
                    o_drop_count <= r_drops;
                    if (r_sl == SLAST) begin
                        o_word_low <= w_meta[63:0];
                        o_word_high <= w_meta[127:64];
                    end else begin
                        o_word_low <= r_wl[r_sl];
                        o_word_high <= r_wh[r_sl];
                        r_sl <= r_sl + 1'b1;
                    end
                end
                default: ;
            endcase
            if (r_state == S_RESP && (!o_valid || i_ready)) begin
                o_status <= r_status;
                o_word_low <= '0;
                o_word_high <= '0;
                o_slot <= '0;
                o_last <= 1'b1;
                o_pending <= (r_rp != r_wp) || w_due_now;
                o_drop_count <= r_drops;
            end
        end
    end

    // sequencer; pending is computed after state updates by a tracker pass (S_DUE)
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                unique case (t_kind'(i_kind))
                    KIND_ENQ: n_state = i_replace_same_sensor ? S_SREAD : S_WRITE;
                    KIND_REP: n_state = S_DREAD;
                    default:  n_state = S_WRITE;
                endcase
            end
            S_SREAD: n_state = w_scan_end ? S_WRITE : S_SCMP;
            S_SCMP:  n_state = w_hit ? S_WRITE : S_SREAD;
            S_WRITE: n_state = S_DUE;
            S_DREAD: n_state = S_DWAIT;
            S_DWAIT: n_state = (r_nq == SW'(DATA_SLOTS) || w_scan_end) ? S_DUE : S_DTAKE;
            S_DTAKE: n_state = S_DWAIT;
            S_DUE: if (r_tcnt == (TW+1)'(TRACKER_COUNT)) begin
                if (r_kind == KIND_REP && !(r_nq == '0 && !w_due_now)) n_state = S_REG;
                else n_state = S_RESP;
            end
            S_REG: if (r_sl == SLAST || !r_fill) n_state = S_FINISH;
            S_FINISH: n_state = S_EMIT;
            S_RESP: if (!o_valid || i_ready) n_state = S_IDLE;
            S_EMIT: if ((!o_valid || i_ready) && r_sl == SLAST) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // r_any stays valid through a report: the tracker table does not change
    // while the report is built and emitted

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_ready)
        else $error("accepted a second item while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_kind == KIND_ENQ))
        else $error("queue write outside enqueue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DTAKE) |-> (r_rp != r_wp))
        else $error("drained an empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && i_ready && r_state == S_IDLE) |-> o_ready)
        else $error("idle without ready");
endmodule
